[design/iirfc_pkg.sv]
// Package for the IIR filter with output constraint.
// Widths, register indexes, coefficient lane select, saturation helpers and divider structs.
// No dependencies.
`timescale 1ns / 1ps

package iirfc_pkg;

  localparam int ORDER = 4;
  localparam int OW    = 2;          // tap index width
  localparam int CW    = 16;         // Q2.14 coefficient
  localparam int SW    = 32;         // Q16.16 sample
  localparam int HW    = 48;         // output history entry
  localparam int AW    = 53;         // accumulator
  localparam int PW    = CW + HW;    // product
  localparam int FRAC  = 14;
  localparam int DVW   = 62;         // divider dividend / quotient
  localparam int DSW   = 31;         // divider divisor / remainder
  localparam int CNTW  = 6;
  localparam int RW    = 64;         // config data width
  localparam int IXW   = 3;          // config index width

  localparam logic [CNTW-1:0] DIV_ITERS   = CNTW'(DVW);
  localparam logic [CNTW-1:0] QUANT_ITERS = CNTW'(SW + 1);

  localparam logic [IXW-1:0] CFG_ORDER = 3'd0;
  localparam logic [IXW-1:0] CFG_DEN   = 3'd1;
  localparam logic [IXW-1:0] CFG_NUM   = 3'd2;
  localparam logic [IXW-1:0] CFG_FLAGS = 3'd3;
  localparam logic [IXW-1:0] CFG_MIN   = 3'd4;
  localparam logic [IXW-1:0] CFG_MAX   = 3'd5;
  localparam logic [IXW-1:0] CFG_STEP  = 3'd6;

  typedef struct packed {
    logic            start;
    logic [CNTW-1:0] iters;
    logic [DVW-1:0]  dividend;
    logic [DSW-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic           done;
    logic [DVW-1:0] quot;
    logic [DSW-1:0] rem;
  } div_rsp_t;

  function automatic logic signed [CW-1:0] coef_lane(input logic [RW-1:0] p,
                                                      input logic [OW-1:0] i);
    return $signed(p[CW*i +: CW]);
  endfunction

  function automatic logic hist_ovf(input logic signed [AW-1:0] v);
    return !((&v[AW-1:HW-1]) || (~|v[AW-1:HW-1]));
  endfunction

  function automatic logic signed [HW-1:0] hist_sat(input logic signed [AW-1:0] v);
    logic signed [HW-1:0] r;
    if (hist_ovf(v)) r = v[AW-1] ? {1'b1, {(HW-1){1'b0}}} : {1'b0, {(HW-1){1'b1}}};
    else r = v[HW-1:0];
    return r;
  endfunction

endpackage

[design/iirfc_div.sv]
// Shared restoring divider, one quotient bit per cycle, MSB first.
// Depends on iirfc_pkg (div_req_t, div_rsp_t).
`timescale 1ns / 1ps

module iirfc_div import iirfc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic            busy_r;
  logic            done_r;
  logic [CNTW-1:0] cnt_r;
  logic [DVW-1:0]  dvd_r;
  logic [DVW-1:0]  quo_r;
  logic [DSW-1:0]  rem_r;
  logic [DSW-1:0]  dsr_r;

  logic [DSW:0]    rem_sh;
  logic [DSW+1:0]  diff;

  assign rem_sh = {rem_r, dvd_r[DVW-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.iters;
        dvd_r  <= req.dividend;
        dsr_r  <= req.divisor;
        quo_r  <= '0;
        rem_r  <= '0;
      end else if (busy_r) begin
        dvd_r <= {dvd_r[DVW-2:0], 1'b0};
        if (!diff[DSW+1]) begin
          rem_r <= diff[DSW-1:0];
          quo_r <= {quo_r[DVW-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh[DSW-1:0];
          quo_r <= {quo_r[DVW-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;
  assign rsp.rem  = rem_r;

endmodule

[design/iir_filter_with_output_constraint_top.sv]
// IIR filter with output clamp and quantization; one result word per input word.
// Steps from accept to out_valid: feedback pass (no taps for n = 1), feedforward pass, a0
// divide (skipped for a zero a0), clamp, quantize when enabled, output (n = taps in use).
// Input ready only when idle: a new word is taken only after the last result is loaded,
// later while a result word waits on out_ready.
// Reset (rst_n, synchronous): histories cleared, registers to order 1, a0 = 1.0.
`timescale 1ns / 1ps

module iir_filter_with_output_constraint_top import iirfc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [IXW-1:0]       cfg_index,
  input  logic [RW-1:0]        cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [SW-1:0] in_sample_in,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [SW-1:0] out_filtered_out,
  output logic                 out_saturated
);

  typedef enum logic [2:0] {
    S_IDLE, S_FB, S_FF, S_DIV, S_CLAMP, S_QUANT, S_OUT
  } state_t;

  // configuration
  logic [2:0]          order_r;
  logic [RW-1:0]       den_r;
  logic [RW-1:0]       num_r;
  logic [2:0]          flags_r;
  logic signed [SW-1:0] min_r;
  logic signed [SW-1:0] max_r;
  logic [DSW-1:0]      step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= 3'd1;
      den_r   <= RW'(16384);
      num_r   <= '0;
      flags_r <= '0;
      min_r   <= '0;
      max_r   <= '0;
      step_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ORDER: order_r <= cfg_wdata[2:0];
        CFG_DEN:   den_r   <= cfg_wdata;
        CFG_NUM:   num_r   <= cfg_wdata;
        CFG_FLAGS: flags_r <= cfg_wdata[2:0];
        CFG_MIN:   min_r   <= $signed(cfg_wdata[SW-1:0]);
        CFG_MAX:   max_r   <= $signed(cfg_wdata[SW-1:0]);
        CFG_STEP:  step_r  <= cfg_wdata[DSW-1:0];
        default: ;
      endcase
    end
  end

  state_t               state_r;
  logic signed [SW-1:0] ih_r [ORDER];
  logic signed [HW-1:0] oh_r [ORDER];
  logic [OW-1:0]        k_r;
  logic                 mph_r;      // MAC: 0 multiply, 1 accumulate; else divider started
  logic signed [PW-1:0] prod_r;
  logic signed [AW-1:0] acc_r;
  logic signed [SW-1:0] y_r;
  logic                 sat_r;
  logic                 out_valid_r;
  logic signed [SW-1:0] out_y_r;
  logic                 out_sat_r;

  // taps in use, clamped to 1..ORDER, as a last index
  logic [OW-1:0] last_k;
  always_comb begin
    if (order_r == 3'd0) last_k = '0;
    else if (order_r > 3'(ORDER)) last_k = OW'(ORDER - 1);
    else last_k = OW'(order_r - 3'd1);
  end

  // shared multiplier
  logic signed [CW-1:0] coef;
  logic signed [HW-1:0] opnd;
  logic signed [PW-1:0] prod;
  logic signed [AW-1:0] term;
  logic signed [AW-1:0] acc_fb;
  logic signed [AW-1:0] acc_ff;
  always_comb begin
    if (state_r == S_FB) begin
      coef = coef_lane(den_r, k_r);
      opnd = oh_r[k_r];
    end else begin
      coef = coef_lane(num_r, k_r);
      opnd = HW'(ih_r[k_r]);
    end
  end
  assign prod   = coef * opnd;
  assign term   = AW'(prod_r >>> FRAC);
  assign acc_fb = acc_r - term;
  assign acc_ff = acc_r + term;

  // divide by a0
  logic signed [CW-1:0] a0;
  logic [HW-1:0]        head_mag;
  logic                 q_neg;
  logic [SW:0]          q_negv;
  logic signed [SW-1:0] y_div;
  logic                 div_ovf;
  div_req_t             div_req;
  div_rsp_t             div_rsp;

  assign a0       = coef_lane(den_r, OW'(0));
  assign head_mag = oh_r[0][HW-1] ? HW'(-oh_r[0]) : oh_r[0];
  assign q_neg    = oh_r[0][HW-1] ^ a0[CW-1];
  assign q_negv   = (SW+1)'(0) - {1'b0, div_rsp.quot[SW-1:0]};

  always_comb begin
    div_ovf = 1'b0;
    y_div   = $signed(div_rsp.quot[SW-1:0]);
    if (!q_neg) begin
      if (div_rsp.quot > DVW'(32'h7FFF_FFFF)) begin
        div_ovf = 1'b1;
        y_div   = {1'b0, {(SW-1){1'b1}}};
      end
    end else begin
      if (div_rsp.quot > DVW'(32'h8000_0000)) begin
        div_ovf = 1'b1;
        y_div   = {1'b1, {(SW-1){1'b0}}};
      end else begin
        y_div = $signed(q_negv[SW-1:0]);
      end
    end
  end

  // quantization: y - floor-mod(y - min, step)
  logic signed [SW:0]   qd;
  logic [SW:0]          qd_mag;
  logic [DSW-1:0]       qm;
  logic signed [SW+1:0] yq;
  logic signed [SW-1:0] yq_sat;
  assign qd     = (SW+1)'(y_r) - (SW+1)'(min_r);
  assign qd_mag = qd[SW] ? (SW+1)'(-qd) : qd;
  always_comb begin
    if (!qd[SW]) qm = div_rsp.rem;
    else if (div_rsp.rem == '0) qm = '0;
    else qm = step_r - div_rsp.rem;
  end
  assign yq = (SW+2)'(y_r) - (SW+2)'($signed({1'b0, qm}));
  assign yq_sat = (yq < -(SW+2)'(64'sh8000_0000)) ? {1'b1, {(SW-1){1'b0}}} : yq[SW-1:0];

  always_comb begin
    div_req.start    = 1'b0;
    div_req.iters    = DIV_ITERS;
    div_req.dividend = {head_mag, {FRAC{1'b0}}};
    div_req.divisor  = DSW'($unsigned(a0[CW-1] ? CW'(-a0) : a0));
    if (state_r == S_DIV) begin
      div_req.start = !mph_r && (a0 != '0);
    end else if (state_r == S_QUANT) begin
      div_req.start    = !mph_r;
      div_req.iters    = QUANT_ITERS;
      div_req.dividend = {qd_mag, {(DVW-SW-1){1'b0}}};
      div_req.divisor  = step_r;
    end
  end

  iirfc_div u_div (
    .clk (clk),
    .rst_n(rst_n),
    .req (div_req),
    .rsp (div_rsp)
  );

  logic ordered;
  logic out_load;
  assign ordered  = min_r < max_r;
  assign in_ready = (state_r == S_IDLE);
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      k_r         <= '0;
      mph_r       <= 1'b0;
      sat_r       <= 1'b0;
      for (int i = 0; i < ORDER; i++) begin
        ih_r[i] <= '0;
        oh_r[i] <= '0;
      end
    end else begin
      if (out_load) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            for (int i = 1; i < ORDER; i++) begin
              if (OW'(i) <= last_k) begin
                ih_r[i] <= ih_r[i-1];
                oh_r[i] <= oh_r[i-1];
              end
            end
            ih_r[0] <= in_sample_in;
            acc_r   <= '0;
            sat_r   <= 1'b0;
            mph_r   <= 1'b0;
            k_r     <= OW'(1);
            state_r <= S_FB;
          end
        end
        S_FB: begin
          if (last_k == '0) begin
            oh_r[0] <= '0;
            acc_r   <= '0;
            k_r     <= '0;
            state_r <= S_FF;
          end else if (!mph_r) begin
            prod_r <= prod;
            mph_r  <= 1'b1;
          end else begin
            mph_r <= 1'b0;
            if (k_r == last_k) begin
              oh_r[0] <= hist_sat(acc_fb);
              acc_r   <= AW'(hist_sat(acc_fb));
              sat_r   <= sat_r | hist_ovf(acc_fb);
              k_r     <= '0;
              state_r <= S_FF;
            end else begin
              acc_r <= acc_fb;
              k_r   <= k_r + 1'b1;
            end
          end
        end
        S_FF: begin
          if (!mph_r) begin
            prod_r <= prod;
            mph_r  <= 1'b1;
          end else begin
            mph_r <= 1'b0;
            if (k_r == last_k) begin
              oh_r[0] <= hist_sat(acc_ff);
              sat_r   <= sat_r | hist_ovf(acc_ff);
              state_r <= S_DIV;
            end else begin
              acc_r <= acc_ff;
              k_r   <= k_r + 1'b1;
            end
          end
        end
        S_DIV: begin
          if (a0 == '0) begin
            // zero divisor: sign of head at full scale, zero for a zero head
            sat_r <= 1'b1;
            if (oh_r[0] == '0) y_r <= '0;
            else if (oh_r[0][HW-1]) y_r <= {1'b1, {(SW-1){1'b0}}};
            else y_r <= {1'b0, {(SW-1){1'b1}}};
            state_r <= S_CLAMP;
          end else if (!mph_r) begin
            mph_r <= 1'b1;
          end else if (div_rsp.done) begin
            mph_r   <= 1'b0;
            y_r     <= y_div;
            sat_r   <= sat_r | div_ovf;
            state_r <= S_CLAMP;
          end
        end
        S_CLAMP: begin
          if (flags_r[0] && (y_r < min_r) && ordered) y_r <= min_r;
          else if (flags_r[1] && (y_r > max_r) && ordered) y_r <= max_r;
          mph_r <= 1'b0;
          if (flags_r[2] && (step_r != '0)) state_r <= S_QUANT;
          else state_r <= S_OUT;
        end
        S_QUANT: begin
          if (!mph_r) begin
            mph_r <= 1'b1;
          end else if (div_rsp.done) begin
            mph_r   <= 1'b0;
            y_r     <= yq_sat;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            out_y_r     <= y_r;
            out_sat_r   <= sat_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_filtered_out = out_y_r;
  assign out_saturated    = out_sat_r;

`ifndef SYNTHESIS
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_DIV || state_r == S_QUANT))
    else $error("divider finished outside a divide state");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && out_valid_r && !out_ready) |=> state_r == S_OUT)
    else $error("result overwrote a pending output word");
  a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_FB && !out_valid_r) || state_r == S_FB)
    else $error("accepted word did not start the feedback pass");
  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |=> !div_rsp.done)
    else $error("divider done right after start");
`endif

endmodule
